/* sv/modbus_rtu_response_parser_macros.svh */
// assertion macros used by the response parser core
`ifndef MODBUS_RTU_RESPONSE_PARSER_MACROS_SVH
`define MODBUS_RTU_RESPONSE_PARSER_MACROS_SVH

// same-cycle implication, checked on clk with rst_n low masking
`define MRP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("parser check failed");

// next-cycle implication, checked on clk with rst_n low masking
`define MRP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("parser check failed");

`endif

/* sv/mrp_pkg.sv */
// types, constants and the crc byte update for the response parser
`timescale 1ns / 1ps

package mrp_pkg;

    // payload limit default and fixed frame constants
    localparam int MAX_PAYLOAD_DEF = 16;
    localparam int DIST_BASE = 6;
    localparam int DIST_BYTES = 6;

    localparam logic [7:0] FUNC_READ = 8'h04;
    localparam logic [7:0] FUNC_WRITE_SINGLE = 8'h06;
    localparam logic [7:0] FUNC_WRITE_MULTI = 8'h10;

    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'hA001;

    // configuration port
    localparam int APB_ADDR_W = 2;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-1:0] REG_SLAVE_ADDRESS = 2'd0;
    localparam logic [7:0] SLAVE_ADDRESS_RESET = 8'h01;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_FUNC    = 3'd1,
        PH_COUNT   = 3'd2,
        PH_PAYLOAD = 3'd3,
        PH_WRITE   = 3'd4,
        PH_DISCARD = 3'd5
    } phase_t;

    typedef enum logic [2:0] {
        ST_NONE          = 3'd0,
        ST_READ_OK       = 3'd1,
        ST_WRITE_OK      = 3'd2,
        ST_CRC_BAD       = 3'd3,
        ST_COUNT_REFUSED = 3'd4,
        ST_HEADER_BAD    = 3'd5
    } frame_status_t;

    typedef struct packed {
        frame_status_t status;
        logic [15:0]   distance_first;
        logic [15:0]   distance_second;
        logic [15:0]   distance_third;
        logic          crc_flag;
    } mrp_result_t;

    // one byte through the reflected crc-16
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        c = crc_in ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

/* sv/mrp_if.sv */
// valid/ready channel interfaces for received bytes and frame results
`timescale 1ns / 1ps

interface mrp_in_if;
    logic       valid;
    logic       ready;
    logic       req_type;
    logic [7:0] rx_byte;

    modport source (output valid, output req_type, output rx_byte, input ready);
    modport sink (input valid, input req_type, input rx_byte, output ready);
endinterface

interface mrp_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  frame_status;
    logic [15:0] distance_first;
    logic [15:0] distance_second;
    logic [15:0] distance_third;
    logic        crc_error_flag;

    modport source (
        output valid, output frame_status, output distance_first,
        output distance_second, output distance_third, output crc_error_flag,
        input ready
    );
    modport sink (
        input valid, input frame_status, input distance_first,
        input distance_second, input distance_third, input crc_error_flag,
        output ready
    );
endinterface

/* sv/mrp_cfg_regs.sv */
// apb configuration register holding the expected slave address
`timescale 1ns / 1ps

module mrp_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mrp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mrp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready,
    output logic [7:0]                     slave_address
);

    logic [7:0] slave_address_reg;
    logic [7:0] slave_address_next;
    logic       wr_en;

    // write decode
    assign wr_en = psel && penable && pwrite && pready;

    always_comb
    begin
        slave_address_next = slave_address_reg;
        if (wr_en && (paddr == mrp_pkg::REG_SLAVE_ADDRESS))
            slave_address_next = pwdata[7:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            slave_address_reg <= mrp_pkg::SLAVE_ADDRESS_RESET;
        else
            slave_address_reg <= slave_address_next;
    end

    // read mux
    always_comb
    begin
        unique case (paddr)
            mrp_pkg::REG_SLAVE_ADDRESS: prdata = {{(mrp_pkg::APB_DATA_W-8){1'b0}},
                                                  slave_address_reg};
            default:                    prdata = '0;
        endcase
    end

    assign pready = 1'b1;
    assign slave_address = slave_address_reg;

endmodule

/* sv/mrp_parser_core.sv */
// frame parse state, running crc and distance byte buffer
`timescale 1ns / 1ps
`include "modbus_rtu_response_parser_macros.svh"

module mrp_parser_core #(
    parameter int MAX_PAYLOAD = mrp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           slave_address,
    input  logic                 item_valid,
    input  logic                 req_type,
    input  logic [7:0]           rx_byte,
    output mrp_pkg::mrp_result_t result
);

    localparam int BufDepth = MAX_PAYLOAD + 6;
    localparam int PosW = $clog2(BufDepth + 1);
    localparam int LenW = $clog2(MAX_PAYLOAD + 1);

    mrp_pkg::phase_t phase_reg, phase_next;
    logic [PosW-1:0] wpos_reg, wpos_next;
    logic [PosW-1:0] pcnt_reg, pcnt_next;
    logic [LenW-1:0] plen_reg, plen_next;
    logic            sticky_reg, sticky_next;
    logic [15:0]     crc_reg, crc_next;
    logic [15:0]     crc_prev_reg, crc_prev_next;
    logic [7:0]      last_byte_reg, last_byte_next;
    logic [7:0]      count_hi_reg, count_hi_next;
    logic [7:0]      dist_reg [mrp_pkg::DIST_BYTES];
    logic [7:0]      dist_next [mrp_pkg::DIST_BYTES];

    logic            store_req;
    logic [PosW-1:0] store_pos;
    logic            store_en;
    logic            crc_ok;
    mrp_pkg::frame_status_t status;

    // frame check: crc over all bytes before the trailer against the two trailer bytes
    assign crc_ok = (crc_prev_reg == {rx_byte, last_byte_reg});

    // buffer position for this byte, address byte always lands at zero
    assign store_req = item_valid && !req_type && (phase_reg == mrp_pkg::PH_IDLE ||
                       phase_reg == mrp_pkg::PH_FUNC || phase_reg == mrp_pkg::PH_COUNT ||
                       phase_reg == mrp_pkg::PH_PAYLOAD || phase_reg == mrp_pkg::PH_WRITE) &&
                       !(phase_reg == mrp_pkg::PH_IDLE && rx_byte != slave_address);
    assign store_pos = (phase_reg == mrp_pkg::PH_IDLE) ? '0 : wpos_reg;
    assign store_en  = store_req && (store_pos < PosW'(BufDepth));

    // byte store, crc update and distance buffer
    always_comb
    begin
        crc_next       = crc_reg;
        crc_prev_next  = crc_prev_reg;
        last_byte_next = last_byte_reg;
        for (int k = 0; k < mrp_pkg::DIST_BYTES; k++)
            dist_next[k] = dist_reg[k];
        if (store_en) begin
            crc_prev_next  = (store_pos == '0) ? mrp_pkg::CRC_INIT : crc_reg;
            crc_next       = mrp_pkg::crc_byte(crc_prev_next, rx_byte);
            last_byte_next = rx_byte;
            for (int k = 0; k < mrp_pkg::DIST_BYTES; k++)
                if (store_pos == PosW'(mrp_pkg::DIST_BASE + k))
                    dist_next[k] = rx_byte;
        end
    end

    // phase and counter update
    always_comb
    begin
        phase_next    = phase_reg;
        wpos_next     = wpos_reg;
        pcnt_next     = pcnt_reg;
        plen_next     = plen_reg;
        sticky_next   = sticky_reg;
        count_hi_next = count_hi_reg;
        status        = mrp_pkg::ST_NONE;
        if (store_en)
            wpos_next = store_pos + PosW'(1);
        if (item_valid) begin
            if (req_type) begin
                phase_next = mrp_pkg::PH_IDLE;
                wpos_next  = '0;
                pcnt_next  = '0;
            end else begin
                unique case (phase_reg)
                    mrp_pkg::PH_IDLE:
                    begin
                        if (rx_byte == slave_address) begin
                            phase_next = mrp_pkg::PH_FUNC;
                        end else begin
                            phase_next = mrp_pkg::PH_DISCARD;
                            wpos_next  = '0;
                            status     = mrp_pkg::ST_HEADER_BAD;
                        end
                    end
                    mrp_pkg::PH_FUNC:
                    begin
                        pcnt_next = '0;
                        if (rx_byte == mrp_pkg::FUNC_READ) begin
                            phase_next = mrp_pkg::PH_COUNT;
                        end else if (rx_byte == mrp_pkg::FUNC_WRITE_SINGLE ||
                                     rx_byte == mrp_pkg::FUNC_WRITE_MULTI) begin
                            phase_next = mrp_pkg::PH_WRITE;
                        end else begin
                            phase_next = mrp_pkg::PH_DISCARD;
                            wpos_next  = '0;
                            status     = mrp_pkg::ST_HEADER_BAD;
                        end
                    end
                    mrp_pkg::PH_COUNT:
                    begin
                        pcnt_next = pcnt_reg + PosW'(1);
                        if (pcnt_reg == PosW'(0)) begin
                            count_hi_next = rx_byte;
                        end else begin
                            pcnt_next = '0;
                            if (count_hi_reg == 8'h00 && rx_byte <= 8'(MAX_PAYLOAD)) begin
                                plen_next  = LenW'(rx_byte);
                                phase_next = mrp_pkg::PH_PAYLOAD;
                            end else begin
                                phase_next = mrp_pkg::PH_IDLE;
                                wpos_next  = '0;
                                status     = mrp_pkg::ST_COUNT_REFUSED;
                            end
                        end
                    end
                    mrp_pkg::PH_PAYLOAD:
                    begin
                        pcnt_next = pcnt_reg + PosW'(1);
                        if (pcnt_reg == PosW'(plen_reg) + PosW'(1)) begin
                            if (crc_ok) begin
                                sticky_next = 1'b0;
                                status      = mrp_pkg::ST_READ_OK;
                            end else begin
                                sticky_next = 1'b1;
                                status      = mrp_pkg::ST_CRC_BAD;
                            end
                            phase_next = mrp_pkg::PH_IDLE;
                            wpos_next  = '0;
                            pcnt_next  = '0;
                        end
                    end
                    mrp_pkg::PH_WRITE:
                    begin
                        pcnt_next = pcnt_reg + PosW'(1);
                        if (pcnt_reg == PosW'(2)) begin
                            if (crc_ok) begin
                                status = mrp_pkg::ST_WRITE_OK;
                            end else begin
                                sticky_next = 1'b1;
                                status      = mrp_pkg::ST_CRC_BAD;
                            end
                            phase_next = mrp_pkg::PH_IDLE;
                            wpos_next  = '0;
                            pcnt_next  = '0;
                        end
                    end
                    mrp_pkg::PH_DISCARD:
                    begin
                        phase_next = mrp_pkg::PH_DISCARD;
                    end
                    default:
                    begin
                        phase_next = mrp_pkg::PH_IDLE;
                    end
                endcase
            end
        end
    end

    // result fields, distances include a byte stored this cycle
    always_comb
    begin
        result.status          = status;
        result.crc_flag        = sticky_next;
        result.distance_first  = '0;
        result.distance_second = '0;
        result.distance_third  = '0;
        if (status == mrp_pkg::ST_READ_OK) begin
            result.distance_first  = {dist_next[0], dist_next[1]};
            result.distance_second = {dist_next[2], dist_next[3]};
            result.distance_third  = {dist_next[4], dist_next[5]};
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            phase_reg  <= mrp_pkg::PH_IDLE;
            wpos_reg   <= '0;
            pcnt_reg   <= '0;
            plen_reg   <= '0;
            sticky_reg <= 1'b0;
            for (int k = 0; k < mrp_pkg::DIST_BYTES; k++)
                dist_reg[k] <= 8'h00;
        end else begin
            phase_reg  <= phase_next;
            wpos_reg   <= wpos_next;
            pcnt_reg   <= pcnt_next;
            plen_reg   <= plen_next;
            sticky_reg <= sticky_next;
            for (int k = 0; k < mrp_pkg::DIST_BYTES; k++)
                dist_reg[k] <= dist_next[k];
        end
    end

    // crc and header scratch
    always_ff @(posedge clk)
    begin
        crc_reg       <= crc_next;
        crc_prev_reg  <= crc_prev_next;
        last_byte_reg <= last_byte_next;
        count_hi_reg  <= count_hi_next;
    end

    // checks
    `MRP_ASSERT_NOW(a_read_ok_clears_flag, item_valid && result.status == mrp_pkg::ST_READ_OK, !result.crc_flag)
    `MRP_ASSERT_NOW(a_crc_bad_sets_flag, item_valid && result.status == mrp_pkg::ST_CRC_BAD, result.crc_flag)
    `MRP_ASSERT_NOW(a_dist_zero_unless_read, result.status != mrp_pkg::ST_READ_OK, result.distance_first == 16'h0000 && result.distance_third == 16'h0000)
    `MRP_ASSERT_NEXT(a_discard_holds, item_valid && !req_type && phase_reg == mrp_pkg::PH_DISCARD, phase_reg == mrp_pkg::PH_DISCARD)
    `MRP_ASSERT_NOW(a_pos_in_range, 1'b1, wpos_reg <= PosW'(BufDepth))

endmodule

/* sv/modbus_rtu_response_parser.sv */
// Modbus RTU response parser: takes one received byte (or a resync item) per
// transaction and returns exactly one result transaction for each. Sustained
// rate is one transaction per clock; each accepted input is held in the input
// register, goes through the parse step with its crc-16 byte update, and is
// captured in the result register that drives the result channel. The input
// side stalls only while both the input and result registers are full and the
// result side is not ready. slave_address sits at byte address 0 of the APB
// port and resets to 1; write it only while no transaction is in flight.
`timescale 1ns / 1ps

module modbus_rtu_response_parser #(
    parameter int MAX_PAYLOAD = mrp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mrp_in_if.sink                         in_ch,
    mrp_out_if.source                      out_ch,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mrp_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mrp_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);

    logic                 in_valid_reg, in_valid_next;
    logic                 in_req_reg;
    logic [7:0]           in_byte_reg;
    logic                 res_valid_reg, res_valid_next;
    mrp_pkg::mrp_result_t res_reg;
    mrp_pkg::mrp_result_t core_result;
    logic [7:0]           slave_address;
    logic                 advance;
    logic                 proc;

    // configuration register
    mrp_cfg_regs u_cfg (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .slave_address (slave_address)
    );

    // pipeline flow control
    assign advance     = !res_valid_reg || out_ch.ready;
    assign in_ch.ready = !in_valid_reg || advance;
    assign proc        = in_valid_reg && advance;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_ch.ready)
            in_valid_next = in_ch.valid;
        res_valid_next = res_valid_reg;
        if (advance)
            res_valid_next = in_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // input and result payload registers
    always_ff @(posedge clk)
    begin
        if (in_ch.valid && in_ch.ready)
        begin
            in_req_reg  <= in_ch.req_type;
            in_byte_reg <= in_ch.rx_byte;
        end
        if (proc)
            res_reg <= core_result;
    end

    // parse step
    mrp_parser_core #(
        .MAX_PAYLOAD (MAX_PAYLOAD)
    ) u_core (
        .clk           (clk),
        .rst_n         (rst_n),
        .slave_address (slave_address),
        .item_valid    (proc),
        .req_type      (in_req_reg),
        .rx_byte       (in_byte_reg),
        .result        (core_result)
    );

    // result channel
    assign out_ch.valid           = res_valid_reg;
    assign out_ch.frame_status    = res_reg.status;
    assign out_ch.distance_first  = res_reg.distance_first;
    assign out_ch.distance_second = res_reg.distance_second;
    assign out_ch.distance_third  = res_reg.distance_third;
    assign out_ch.crc_error_flag  = res_reg.crc_flag;

endmodule

/* bench/mrp_tb_pkg.sv */
// byte queue type and modbus crc-16 shared by the stimulus and the frame monitor
`timescale 1ns / 1ps

package mrp_tb_pkg;

    import mrp_pkg::*;

    typedef logic [7:0] octet_q_t[$];

    // bitwise crc-16 over a whole byte sequence, init all ones, reflected poly
    function automatic logic [15:0] modbus_crc16(input octet_q_t bytes);
        logic [15:0] crc;
        crc = CRC_INIT;
        foreach (bytes[i])
        begin
            crc = crc ^ {8'h00, bytes[i]};
            repeat (8)
            begin
                crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
            end
        end
        return crc;
    endfunction

endpackage

/* bench/mrp_frame_monitor.sv */
// watches both channels and the apb port, predicts each result and compares it
`timescale 1ns / 1ps

module mrp_frame_monitor #(
    parameter int MAX_PAYLOAD = mrp_pkg::MAX_PAYLOAD_DEF
) (
    input  logic                           clk,
    input  logic                           rst_n,
    mrp_in_if                              in_mon,
    mrp_out_if                             out_mon,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mrp_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mrp_pkg::APB_DATA_W-1:0] pwdata,
    input  logic                           pready,
    output int                             mismatches,
    output int                             results_pending
);

    import mrp_pkg::*;
    import mrp_tb_pkg::*;

    // header (address, function, two count bytes) plus the two crc bytes
    localparam int BUF_DEPTH = MAX_PAYLOAD + 6;

    // parser state as the block should hold it
    logic [7:0]  slave_addr;
    phase_t      phase;
    logic [7:0]  frame_buf [BUF_DEPTH];
    int          wr_pos;
    int          byte_cnt;
    int          payload_len;
    logic        crc_sticky;

    mrp_result_t expected_results[$];
    mrp_result_t predicted;
    mrp_result_t oldest;

    function automatic void push_byte(input logic [7:0] v);
        if (wr_pos < BUF_DEPTH)
        begin
            frame_buf[wr_pos] = v;
            wr_pos++;
        end
    endfunction

    function automatic void close_frame();
        wr_pos = 0;
        byte_cnt = 0;
        phase = PH_IDLE;
    endfunction

    // crc over the first bytes of the buffer against the last two stored bytes
    function automatic bit crc_check(input int covered);
        octet_q_t    span;
        logic [15:0] crc;
        int          len;
        len = (covered > BUF_DEPTH) ? BUF_DEPTH : covered;
        for (int i = 0; i < len; i++)
            span.push_back(frame_buf[i]);
        crc = modbus_crc16(span);
        if (wr_pos < 2)
            return 1'b0;
        return crc[7:0] == frame_buf[wr_pos-2] && crc[15:8] == frame_buf[wr_pos-1];
    endfunction

    // one transaction through the parser, giving the result it must produce
    task automatic advance_parser(input logic resync, input logic [7:0] b,
                                  output mrp_result_t r);
        logic [15:0] count;
        r = '0;
        r.status = ST_NONE;
        if (resync)
        begin
            close_frame();
        end
        else
        begin
            case (phase)
                PH_IDLE:
                begin
                    wr_pos = 0;
                    if (b == slave_addr)
                    begin
                        push_byte(b);
                        phase = PH_FUNC;
                    end
                    else
                    begin
                        phase = PH_DISCARD;
                        r.status = ST_HEADER_BAD;
                    end
                end
                PH_FUNC:
                begin
                    push_byte(b);
                    byte_cnt = 0;
                    if (b == FUNC_READ)
                        phase = PH_COUNT;
                    else if (b == FUNC_WRITE_SINGLE || b == FUNC_WRITE_MULTI)
                        phase = PH_WRITE;
                    else
                    begin
                        phase = PH_DISCARD;
                        wr_pos = 0;
                        r.status = ST_HEADER_BAD;
                    end
                end
                PH_COUNT:
                begin
                    push_byte(b);
                    byte_cnt++;
                    if (byte_cnt == 2)
                    begin
                        count = {frame_buf[2], frame_buf[3]};
                        byte_cnt = 0;
                        if (count <= MAX_PAYLOAD)
                        begin
                            payload_len = int'(count);
                            phase = PH_PAYLOAD;
                        end
                        else
                        begin
                            close_frame();
                            r.status = ST_COUNT_REFUSED;
                        end
                    end
                end
                PH_PAYLOAD:
                begin
                    push_byte(b);
                    byte_cnt++;
                    if (byte_cnt >= payload_len + 2)
                    begin
                        if (crc_check(payload_len + 4))
                        begin
                            crc_sticky = 1'b0;
                            r.status = ST_READ_OK;
                            r.distance_first  = {frame_buf[DIST_BASE],   frame_buf[DIST_BASE+1]};
                            r.distance_second = {frame_buf[DIST_BASE+2], frame_buf[DIST_BASE+3]};
                            r.distance_third  = {frame_buf[DIST_BASE+4], frame_buf[DIST_BASE+5]};
                        end
                        else
                        begin
                            crc_sticky = 1'b1;
                            r.status = ST_CRC_BAD;
                        end
                        close_frame();
                    end
                end
                PH_WRITE:
                begin
                    push_byte(b);
                    byte_cnt++;
                    if (byte_cnt == 3)
                    begin
                        if (crc_check(3))
                            r.status = ST_WRITE_OK;
                        else
                        begin
                            crc_sticky = 1'b1;
                            r.status = ST_CRC_BAD;
                        end
                        close_frame();
                    end
                end
                PH_DISCARD:
                begin
                end
                default:
                    phase = PH_IDLE;
            endcase
        end
        r.crc_flag = crc_sticky;
    endtask

    function automatic void check_field(input string field, input logic [15:0] want,
                                        input logic [15:0] got);
        if (want !== got)
        begin
            mismatches++;
            $display("%0t: %s expected %0h actual %0h", $time, field, want, got);
        end
    endfunction

    // prediction on each accepted byte, comparison on each accepted result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_addr = SLAVE_ADDRESS_RESET;
            phase = PH_IDLE;
            for (int i = 0; i < BUF_DEPTH; i++)
                frame_buf[i] = 8'h00;
            wr_pos = 0;
            byte_cnt = 0;
            payload_len = 0;
            crc_sticky = 1'b0;
            mismatches = 0;
            expected_results.delete();
            results_pending <= 0;
        end
        else
        begin
            // register write seen on the apb port
            if (psel && penable && pwrite && pready && paddr == REG_SLAVE_ADDRESS)
                slave_addr = pwdata[7:0];

            if (in_mon.valid && in_mon.ready)
            begin
                advance_parser(in_mon.req_type, in_mon.rx_byte, predicted);
                expected_results.push_back(predicted);
            end

            if (out_mon.valid && out_mon.ready)
            begin
                if (expected_results.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: result transaction with nothing expected, status %0h",
                             $time, out_mon.frame_status);
                end
                else
                begin
                    oldest = expected_results.pop_front();
                    check_field("frame_status", 16'(oldest.status), 16'(out_mon.frame_status));
                    check_field("distance_first", oldest.distance_first,
                                out_mon.distance_first);
                    check_field("distance_second", oldest.distance_second,
                                out_mon.distance_second);
                    check_field("distance_third", oldest.distance_third,
                                out_mon.distance_third);
                    check_field("crc_error_flag", 16'(oldest.crc_flag),
                                16'(out_mon.crc_error_flag));
                end
            end

            results_pending <= expected_results.size();
        end
    end

endmodule

/* bench/modbus_rtu_response_parser_tb.sv */
// testbench top: clock, reset, byte and apb stimulus, result backpressure, verdict
`timescale 1ns / 1ps

module modbus_rtu_response_parser_tb;

    import mrp_pkg::*;
    import mrp_tb_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int HOLD_CYCLES = 150;

    logic clk = 1'b0;
    logic rst_n;

    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int results_pending;

    int         items_sent = 0;
    int         cycle_count = 0;
    int         stim_phase = 0;
    bit         quiet = 1'b0;
    bit         sender_pauses = 1'b1;
    logic [7:0] cur_addr = SLAVE_ADDRESS_RESET;

    mrp_in_if  in_ch ();
    mrp_out_if out_ch ();

    modbus_rtu_response_parser dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    mrp_frame_monitor frame_monitor (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_mon          (in_ch),
        .out_mon         (out_ch),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .mismatches      (mismatches),
        .results_pending (results_pending)
    );

    always #2 clk = ~clk;

    // run length guard
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // mostly random data, with the all-zero and all-one bytes favored
    function automatic logic [7:0] random_octet();
        case ($urandom_range(0, 7))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic octet_q_t read_frame(input logic [7:0] addr, input int n);
        octet_q_t q;
        q = {addr, FUNC_READ, 8'h00, 8'(n)};
        repeat (n)
            q.push_back(random_octet());
        return q;
    endfunction

    // one transaction on the byte channel, with an optional idle burst first
    task automatic offer(input logic resync, input logic [7:0] b);
        if (sender_pauses && !quiet && $urandom_range(0, 5) == 0)
        begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18))
                @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.req_type <= resync;
        in_ch.rx_byte <= b;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
    endtask

    task automatic send_bytes(input octet_q_t q);
        foreach (q[i])
            offer(1'b0, q[i]);
    endtask

    // appends the crc, optionally flipping one bit at or after flip_from
    task automatic send_with_crc(input octet_q_t q, input bit corrupt, input int flip_from);
        logic [15:0] crc;
        int          k;
        crc = modbus_crc16(q);
        q.push_back(crc[7:0]);
        q.push_back(crc[15:8]);
        if (corrupt)
        begin
            k = $urandom_range(flip_from, q.size() - 1);
            q[k] = q[k] ^ (8'h01 << $urandom_range(0, 7));
        end
        send_bytes(q);
    endtask

    task automatic wait_for_drain();
        in_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (results_pending != 0);
        repeat (4)
            @(posedge clk);
    endtask

    task automatic write_slave_address(input logic [7:0] a);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= REG_SLAVE_ADDRESS;
        pwdata <= APB_DATA_W'(a);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_addr = a;
    endtask

    // one random frame, mostly well formed, preceded by a frame gap most of the time
    task automatic send_frame();
        octet_q_t   q;
        int         pick;
        int         n;
        logic [7:0] func;
        logic [7:0] count_hi;
        logic [7:0] count_lo;
        sender_pauses = ($urandom_range(0, 2) != 0);
        n = ($urandom_range(0, 3) == 0) ? MAX_PAYLOAD_DEF : $urandom_range(0, MAX_PAYLOAD_DEF);
        if ($urandom_range(0, 99) < 85)
            offer(1'b1, random_octet());
        pick = $urandom_range(0, 99);
        if (pick < 45)
            send_with_crc(read_frame(cur_addr, n), 1'b0, 0);
        else if (pick < 60 || (pick >= 66 && pick < 71))
        begin
            func = $urandom_range(0, 1) ? FUNC_WRITE_SINGLE : FUNC_WRITE_MULTI;
            q = {cur_addr, func, random_octet()};
            send_with_crc(q, pick >= 66, 2);
        end
        else if (pick < 66)
            send_with_crc(read_frame(cur_addr, n), 1'b1, 4);
        else if (pick < 78)
        begin
            // byte count above the limit, then some trailing bytes
            case ($urandom_range(0, 2))
                0:
                begin
                    count_hi = 8'h00;
                    count_lo = 8'(MAX_PAYLOAD_DEF + 1);
                end
                1:
                begin
                    count_hi = 8'h00;
                    count_lo = 8'($urandom_range(MAX_PAYLOAD_DEF + 1, 255));
                end
                default:
                begin
                    count_hi = 8'($urandom_range(1, 255));
                    count_lo = random_octet();
                end
            endcase
            q = {cur_addr, FUNC_READ, count_hi, count_lo};
            repeat ($urandom_range(0, 3))
                q.push_back(random_octet());
            send_bytes(q);
        end
        else if (pick < 84)
        begin
            q = {cur_addr ^ 8'($urandom_range(1, 255))};
            repeat ($urandom_range(0, 5))
                q.push_back(random_octet());
            send_bytes(q);
        end
        else if (pick < 90)
        begin
            do
                func = random_octet();
            while (func == FUNC_READ || func == FUNC_WRITE_SINGLE || func == FUNC_WRITE_MULTI);
            q = {cur_addr, func, random_octet()};
            send_bytes(q);
        end
        else if (pick < 95)
        begin
            // frame cut short by a gap
            q = read_frame(cur_addr, n);
            q = q[0:$urandom_range(0, q.size() - 1)];
            send_bytes(q);
            offer(1'b1, random_octet());
        end
        else
        begin
            repeat ($urandom_range(1, 6))
                q.push_back(random_octet());
            send_bytes(q);
        end
    endtask

    // result side: random stalls, one long hold-off, none at the end
    initial
    begin
        bit held_off;
        held_off = 1'b0;
        out_ch.ready <= 1'b0;
        do
            @(posedge clk);
        while (!rst_n);
        forever
        begin
            if (stim_phase == 1 && !held_off)
            begin
                held_off = 1'b1;
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES)
                    @(posedge clk);
            end
            else if (!quiet && $urandom_range(0, 11) == 0)
            begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 18))
                    @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge clk);
        end
    end

    // stimulus and verdict
    initial
    begin
        rst_n <= 1'b0;
        in_ch.valid <= 1'b0;
        in_ch.req_type <= 1'b0;
        in_ch.rx_byte <= 8'h00;
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= '0;
        pwdata <= '0;
        repeat (11)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: write echoes, header errors, refused count, empty read
        offer(1'b1, 8'h00);
        send_with_crc({cur_addr, FUNC_WRITE_SINGLE, 8'hA5}, 1'b0, 0);
        send_with_crc({cur_addr, FUNC_WRITE_MULTI, 8'h00}, 1'b1, 2);
        send_bytes({8'h00, 8'hFF});
        offer(1'b1, 8'hFF);
        send_bytes({cur_addr, 8'h03});
        offer(1'b1, 8'h00);
        send_bytes({cur_addr, FUNC_READ, 8'hFF, 8'hFF});
        send_with_crc({cur_addr, FUNC_READ, 8'h00, 8'h00}, 1'b0, 0);

        // random frames under the reset address
        while (items_sent < 175)
            send_frame();

        // lowest address, with the long result hold-off
        wait_for_drain();
        write_slave_address(8'h00);
        stim_phase <= 1;
        while (items_sent < 350)
            send_frame();

        // highest address
        wait_for_drain();
        write_slave_address(8'hFF);
        stim_phase <= 2;
        while (items_sent < 525)
            send_frame();

        // random address, no idling on either side
        wait_for_drain();
        write_slave_address(8'($urandom_range(2, 254)));
        stim_phase <= 3;
        quiet <= 1'b1;
        while (items_sent < 700)
            send_frame();

        wait_for_drain();
        repeat (8)
            @(posedge clk);
        if (mismatches == 0 && results_pending == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* modbus_rtu_response_parser.f */
+incdir+sv
sv/mrp_pkg.sv
sv/mrp_if.sv
sv/mrp_cfg_regs.sv
sv/mrp_parser_core.sv
sv/modbus_rtu_response_parser.sv
bench/mrp_tb_pkg.sv
bench/mrp_frame_monitor.sv
bench/modbus_rtu_response_parser_tb.sv
